### sv/rsbk_pkg.sv
// shared types and constants for the record sorter
`timescale 1ns / 1ps

package rsbk_pkg;

   // default sizing
   localparam int MAX_RECORDS_DEF = 64;
   localparam int TAG_BITS_DEF    = 16;

   // fixed field widths on the ports
   localparam int KEY_BITS       = 32;
   localparam int FIELD_TAG_BITS = 16;
   localparam int DATA_BITS      = 48;

   // sequencer states
   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } sort_state_type;

   // command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic shift_out;
   } cell_cmd_type;

endpackage

### sv/rsbk_cell.sv
// one insertion cell of the sorting chain
`timescale 1ns / 1ps

module rsbk_cell #(
   parameter int TAG_BITS = rsbk_pkg::TAG_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rsbk_pkg::cell_cmd_type              cmd,
   input  logic [rsbk_pkg::KEY_BITS-1:0]       new_key,
   input  logic [TAG_BITS-1:0]                 new_tag,
   input  logic                                prev_valid,
   input  logic [rsbk_pkg::KEY_BITS-1:0]       prev_key,
   input  logic [TAG_BITS-1:0]                 prev_tag,
   input  logic                                prev_keeps,
   input  logic                                next_valid,
   input  logic [rsbk_pkg::KEY_BITS-1:0]       next_key,
   input  logic [TAG_BITS-1:0]                 next_tag,
   output logic                                valid,
   output logic [rsbk_pkg::KEY_BITS-1:0]       key,
   output logic [TAG_BITS-1:0]                 tag,
   output logic                                keeps
);
   import rsbk_pkg::*;

   logic                valid_ff, valid_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;

   // equal keys stay ahead of the new record, which keeps the sort stable
   assign keeps = valid_ff && (key_ff <= new_key);

   // hold, take the new record, take from the left, or take from the right
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      if (cmd.insert) begin
         if (!keeps) begin
            if (prev_keeps) begin
               valid_in = 1'b1;
               key_in   = new_key;
               tag_in   = new_tag;
            end else begin
               valid_in = prev_valid;
               key_in   = prev_key;
               tag_in   = prev_tag;
            end
         end
      end else if (cmd.shift_out) begin
         valid_in = next_valid;
         key_in   = next_key;
         tag_in   = next_tag;
      end
   end

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // record payload
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign tag   = tag_ff;

endmodule

### sv/record_sort_by_key.sv
// Stable ascending sort of a batch of keyed records. Records stream in on the req_ channel
// and drop into a row of MAX_RECORDS insertion cells, one record per cycle; a record goes
// after every stored record with an equal or smaller key, so ties keep arrival order. The
// record flagged by tlast closes the batch: from the next cycle the chain shifts out on the
// rsp_ channel one record per cycle while rsp_tready is high, lowest key first, tlast on the
// final one and tuser set on all of them if records were dropped because the chain was full.
// No input is taken while a batch drains.
`timescale 1ns / 1ps

module record_sort_by_key #(
   parameter int MAX_RECORDS = rsbk_pkg::MAX_RECORDS_DEF,
   parameter int TAG_BITS    = rsbk_pkg::TAG_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request: [31:0] sort_key, [47:32] record_tag
   input  logic [rsbk_pkg::DATA_BITS-1:0] req_tdata,
   input  logic                           req_tlast,   // batch_end
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // response: [31:0] sorted_key, [47:32] sorted_tag
   output logic [rsbk_pkg::DATA_BITS-1:0] rsp_tdata,
   output logic                           rsp_tlast,   // run_end
   output logic                           rsp_tuser,   // [0] truncated
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready
);
   import rsbk_pkg::*;

   sort_state_type            state_ff, state_in;
   logic                      overflow_ff, overflow_in;
   cell_cmd_type              cmd;
   logic                      in_xfer, out_xfer, full, drain_done;
   logic [KEY_BITS-1:0]       new_key;
   logic [TAG_BITS-1:0]       new_tag;

   logic [MAX_RECORDS-1:0]    cell_valid;
   logic [MAX_RECORDS-1:0]    cell_keeps;
   logic [KEY_BITS-1:0]       cell_key [MAX_RECORDS];
   logic [TAG_BITS-1:0]       cell_tag [MAX_RECORDS];

   // incoming fields
   assign new_key = req_tdata[KEY_BITS-1:0];
   assign new_tag = TAG_BITS'(req_tdata[KEY_BITS +: FIELD_TAG_BITS]);

   // handshake and chain status
   assign req_tready = (state_ff == ST_LOAD);
   assign in_xfer    = req_tvalid && req_tready;
   assign out_xfer   = rsp_tvalid && rsp_tready;
   assign full       = cell_valid[MAX_RECORDS-1];
   assign drain_done = out_xfer && !cell_valid[1];

   assign cmd.insert    = in_xfer && !full;
   assign cmd.shift_out = out_xfer;

   // chain of insertion cells
   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      logic                p_valid, p_keeps, n_valid;
      logic [KEY_BITS-1:0] p_key, n_key;
      logic [TAG_BITS-1:0] p_tag, n_tag;

      if (i == 0) begin : g_head
         assign p_valid = 1'b0;
         assign p_keeps = 1'b1;
         assign p_key   = '0;
         assign p_tag   = '0;
      end else begin : g_body
         assign p_valid = cell_valid[i-1];
         assign p_keeps = cell_keeps[i-1];
         assign p_key   = cell_key[i-1];
         assign p_tag   = cell_tag[i-1];
      end

      if (i == MAX_RECORDS - 1) begin : g_tail
         assign n_valid = 1'b0;
         assign n_key   = '0;
         assign n_tag   = '0;
      end else begin : g_mid
         assign n_valid = cell_valid[i+1];
         assign n_key   = cell_key[i+1];
         assign n_tag   = cell_tag[i+1];
      end

      rsbk_cell #(
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_key    (new_key),
         .new_tag    (new_tag),
         .prev_valid (p_valid),
         .prev_key   (p_key),
         .prev_tag   (p_tag),
         .prev_keeps (p_keeps),
         .next_valid (n_valid),
         .next_key   (n_key),
         .next_tag   (n_tag),
         .valid      (cell_valid[i]),
         .key        (cell_key[i]),
         .tag        (cell_tag[i]),
         .keeps      (cell_keeps[i])
      );
   end

   // next state and overflow flag
   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      case (state_ff)
         ST_LOAD: begin
            if (in_xfer && full) begin
               overflow_in = 1'b1;
            end
            if (in_xfer && req_tlast) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (drain_done) begin
               state_in    = ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in    = ST_LOAD;
            overflow_in = 1'b0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   // head cell drives the response
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {FIELD_TAG_BITS'(cell_tag[0]), cell_key[0]};
   assign rsp_tlast  = !cell_valid[1];
   assign rsp_tuser  = overflow_ff;

   // checks
   localparam logic [MAX_RECORDS-1:0] VEC_ONE = MAX_RECORDS'(1);

   a_fill_prefix : assert property (@(posedge clock) disable iff (reset)
      ((cell_valid + VEC_ONE) & cell_valid) == '0)
      else $error("occupied cells do not form a prefix");

   a_head_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cell_valid[0])
      else $error("response offered from an empty head cell");

   a_no_load_in_drain : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while draining");

   a_ascending : assert property (@(posedge clock) disable iff (reset)
      (out_xfer && !rsp_tlast) |=>
         (rsp_tvalid && (rsp_tdata[KEY_BITS-1:0] >= $past(rsp_tdata[KEY_BITS-1:0]))))
      else $error("run out of ascending key order");

   a_overflow_full : assert property (@(posedge clock) disable iff (reset)
      (overflow_ff && (state_ff == ST_LOAD)) |-> full)
      else $error("overflow flagged while chain not full");

endmodule
